// ----- rtl/lzss_pkg.sv -----
// Shared types and constants for the LZSS 256-byte-window decompressor.
// No dependencies; used by lzss_unpack, lzss_decompressor_256_window and the testbench.
`default_nettype none

package lzss_pkg;

   localparam int unsigned WinDepth  = 256;
   localparam int unsigned WinAddrW  = 8;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned CountW    = 25;
   localparam int unsigned SizeW     = 32;
   localparam int unsigned LenW      = 26;
   localparam int unsigned TokW      = 11;
   localparam int unsigned TokCntW   = 4;
   localparam int unsigned StatW     = 3;

   localparam logic [SizeW-1:0]  MaxOutput   = 32'd16777216;
   localparam logic [SizeW-1:0]  SizeOffset  = 32'd64;
   localparam logic [LenW-1:0]   HeaderBytes = 26'd4;
   localparam logic [4:0]        LitBits     = 5'd9;
   localparam logic [4:0]        MatchBits   = 5'd11;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEADER,
      S_CHECK,
      S_BODY,
      S_LIT,
      S_COPY_RD,
      S_COPY_EMIT,
      S_STATUS
   } state_type;

   typedef enum logic [StatW-1:0] {
      STAT_DATA  = 3'd0,
      STAT_EMPTY = 3'd1,
      STAT_SHORT = 3'd2,
      STAT_CAP   = 3'd3,
      STAT_BOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic               done;
      logic               is_match;
      logic [1:0]         len_code;
      logic [ByteW-1:0]   value;
      logic [TokW-1:0]    next_bits;
      logic [TokCntW-1:0] next_count;
   } token_type;

endpackage

`default_nettype wire

// ----- rtl/lzss_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lzss_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lzss_unpack.sv -----
// Token bit unpacker: merges the partial token with one stream byte, MSB first.
// Depends on lzss_pkg.
`default_nettype none

module lzss_unpack (
   input  wire logic [lzss_pkg::TokW-1:0]    tok_bits,
   input  wire logic [lzss_pkg::TokCntW-1:0] tok_count,
   input  wire logic [lzss_pkg::ByteW-1:0]   in_byte,
   output      lzss_pkg::token_type          tok
);

   logic [18:0] cat;
   logic [4:0]  total;
   logic        flag;
   logic [4:0]  need;
   logic [4:0]  shift;
   logic [18:0] shifted;
   logic [18:0] mask;
   logic [18:0] leftover;

   always_comb begin
      cat      = {tok_bits, in_byte};
      total    = {1'b0, tok_count} + 5'd8;
      flag     = cat[total - 5'd1];
      need     = flag ? lzss_pkg::MatchBits : lzss_pkg::LitBits;
      shift    = total - need;
      shifted  = cat >> shift;
      mask     = (19'd1 << shift) - 19'd1;
      leftover = cat & mask;

      tok.done     = (total >= need);
      tok.is_match = flag;
      tok.len_code = shifted[9:8];
      tok.value    = shifted[7:0];
      if (tok.done) begin
         tok.next_bits  = leftover[10:0];
         tok.next_count = shift[3:0];
      end else begin
         tok.next_bits  = cat[10:0];
         tok.next_count = total[3:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lzss_decompressor_256_window.sv -----
// LZSS decompressor top level: header check, token decode, 256-byte window copy.
// Depends on lzss_pkg, lzss_unpack and lzss_ram.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_byte, req_stream_start
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_end_of_stream, rsp_status
//   csr     | in        | csr_wr_en            | csr_wr_data (input_length)
//
// Header bytes and body bytes that finish no token are taken without holding req.
// The last header byte leads to S_CHECK, which goes on to S_STATUS for a status item or to S_BODY.
// A literal is emitted from S_LIT; a match of 2..5 bytes reads the window RAM, whose
// read data is registered, in S_COPY_RD and emits its bytes from S_COPY_EMIT.
// Reset and stream start clear the window through per-entry valid bits: no sweep.
// A stalled rsp holds the engine; req is taken while a finished item waits in rsp.
`default_nettype none

module lzss_decompressor_256_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [lzss_pkg::ByteW-1:0]    req_in_byte,
   input  wire logic                          req_stream_start,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [lzss_pkg::ByteW-1:0]    rsp_out_byte,
   output      logic                          rsp_end_of_stream,
   output      logic [lzss_pkg::StatW-1:0]    rsp_status,
   input  wire logic                          csr_wr_en,
   input  wire logic [lzss_pkg::LenW-1:0]     csr_wr_data
);

   lzss_pkg::state_type                 state_ff, state_in;
   logic [1:0]                          hdr_count_ff, hdr_count_in;
   logic [lzss_pkg::SizeW-1:0]          decl_size_ff, decl_size_in;
   logic [lzss_pkg::CountW-1:0]         prod_count_ff, prod_count_in;
   logic [lzss_pkg::TokW-1:0]           tok_bits_ff, tok_bits_in;
   logic [lzss_pkg::TokCntW-1:0]        tok_count_ff, tok_count_in;
   logic [lzss_pkg::WinAddrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lzss_pkg::WinAddrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]                          remain_ff, remain_in;
   logic [lzss_pkg::ByteW-1:0]          lit_ff, lit_in;
   lzss_pkg::status_type                stat_code_ff, stat_code_in;
   logic [lzss_pkg::WinDepth-1:0]       win_valid_ff, win_valid_in;
   logic                                rd_valid_ff, rd_valid_in;
   logic                                fwd_ff, fwd_in;
   logic [lzss_pkg::ByteW-1:0]          fwd_data_ff, fwd_data_in;
   logic                                len_short_ff, len_short_in;
   logic [lzss_pkg::SizeW-1:0]          bound_ff, bound_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lzss_pkg::ByteW-1:0]          rsp_byte_ff, rsp_byte_in;
   logic                                rsp_eos_ff, rsp_eos_in;
   logic [lzss_pkg::StatW-1:0]          rsp_stat_ff, rsp_stat_in;

   lzss_pkg::token_type                 tok;
   logic                                req_fire;
   logic                                out_ready;
   logic                                emit_fire;
   logic [lzss_pkg::ByteW-1:0]          emit_data;
   logic [lzss_pkg::CountW-1:0]         prod_next;
   logic                                emit_eos;
   logic                                status_fire;
   logic                                rd_en;
   logic [lzss_pkg::ByteW-1:0]          ram_q;
   logic [lzss_pkg::LenW-1:0]           len_adj;
   logic [24:0]                         size_diff;
   logic [28:0]                         size_scaled;
   logic                                over_bound;

   lzss_unpack u_unpack (
      .tok_bits  (tok_bits_ff),
      .tok_count (tok_count_ff),
      .in_byte   (req_in_byte),
      .tok       (tok)
   );

   lzss_ram #(
      .Width (lzss_pkg::ByteW),
      .Depth (lzss_pkg::WinDepth)
   ) u_window (
      .clock   (clock),
      .wr_en   (emit_fire),
      .wr_addr (wr_ptr_ff),
      .wr_data (emit_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   assign req_stall = !((state_ff == lzss_pkg::S_IDLE) || (state_ff == lzss_pkg::S_HEADER) ||
                        (state_ff == lzss_pkg::S_BODY));
   assign req_fire  = req_valid && !req_stall;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_end_of_stream = rsp_eos_ff;
   assign rsp_status        = rsp_stat_ff;

   assign prod_next = prod_count_ff + 25'd1;
   assign emit_eos  = (prod_next == decl_size_ff[lzss_pkg::CountW-1:0]);

   assign len_adj     = csr_wr_data - lzss_pkg::HeaderBytes;
   assign size_diff   = decl_size_ff[24:0] - lzss_pkg::SizeOffset[24:0];
   assign size_scaled = ({4'd0, size_diff} << 3) + ({4'd0, size_diff} << 1) + {4'd0, size_diff};
   assign over_bound  = (decl_size_ff > lzss_pkg::SizeOffset) &&
                        (bound_ff < {3'd0, size_scaled});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lzss_pkg::S_IDLE;
         hdr_count_ff  <= '0;
         decl_size_ff  <= '0;
         prod_count_ff <= '0;
         tok_bits_ff   <= '0;
         tok_count_ff  <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         remain_ff     <= '0;
         win_valid_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         len_short_ff  <= 1'b1;
         bound_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         stat_code_ff  <= lzss_pkg::STAT_DATA;
      end else begin
         state_ff      <= state_in;
         hdr_count_ff  <= hdr_count_in;
         decl_size_ff  <= decl_size_in;
         prod_count_ff <= prod_count_in;
         tok_bits_ff   <= tok_bits_in;
         tok_count_ff  <= tok_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         remain_ff     <= remain_in;
         win_valid_ff  <= win_valid_in;
         rd_valid_ff   <= rd_valid_in;
         fwd_ff        <= fwd_in;
         len_short_ff  <= len_short_in;
         bound_ff      <= bound_in;
         rsp_valid_ff  <= rsp_valid_in;
         stat_code_ff  <= stat_code_in;
      end
      lit_ff      <= lit_in;
      fwd_data_ff <= fwd_data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_eos_ff  <= rsp_eos_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      state_in      = state_ff;
      hdr_count_in  = hdr_count_ff;
      decl_size_in  = decl_size_ff;
      prod_count_in = prod_count_ff;
      tok_bits_in   = tok_bits_ff;
      tok_count_in  = tok_count_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      remain_in     = remain_ff;
      lit_in        = lit_ff;
      stat_code_in  = stat_code_ff;
      win_valid_in  = win_valid_ff;
      rd_valid_in   = rd_valid_ff;
      fwd_in        = fwd_ff;
      fwd_data_in   = fwd_data_ff;
      len_short_in  = len_short_ff;
      bound_in      = bound_ff;
      emit_fire     = 1'b0;
      emit_data     = lit_ff;
      status_fire   = 1'b0;
      rd_en         = 1'b0;

      if (csr_wr_en) begin
         len_short_in = (csr_wr_data < lzss_pkg::HeaderBytes);
         bound_in     = ({6'd0, len_adj} << 5) + ({6'd0, len_adj} << 3);
      end

      case (state_ff)
         lzss_pkg::S_IDLE, lzss_pkg::S_HEADER, lzss_pkg::S_BODY: begin
            if (req_fire) begin
               if (req_stream_start) begin
                  // restart: clear window and counters, take this byte as header byte one unless the length is short
                  win_valid_in  = '0;
                  wr_ptr_in     = '0;
                  prod_count_in = '0;
                  tok_bits_in   = '0;
                  tok_count_in  = '0;
                  hdr_count_in  = 2'd1;
                  decl_size_in  = {24'd0, req_in_byte};
                  if (len_short_ff) begin
                     hdr_count_in = '0;
                     stat_code_in = lzss_pkg::STAT_SHORT;
                     state_in     = lzss_pkg::S_STATUS;
                  end else begin
                     state_in = lzss_pkg::S_HEADER;
                  end
               end else if (state_ff == lzss_pkg::S_HEADER) begin
                  decl_size_in = {decl_size_ff[23:0], req_in_byte};
                  hdr_count_in = hdr_count_ff + 2'd1;
                  if (hdr_count_ff == 2'd3) begin
                     state_in = lzss_pkg::S_CHECK;
                  end
               end else if (state_ff == lzss_pkg::S_BODY) begin
                  tok_bits_in  = tok.next_bits;
                  tok_count_in = tok.next_count;
                  if (tok.done) begin
                     if (tok.is_match) begin
                        rd_ptr_in = wr_ptr_ff + ~tok.value;
                        remain_in = {1'b0, tok.len_code} + 3'd2;
                        state_in  = lzss_pkg::S_COPY_RD;
                     end else begin
                        lit_in   = tok.value;
                        state_in = lzss_pkg::S_LIT;
                     end
                  end
               end
            end
         end
         lzss_pkg::S_CHECK: begin
            state_in = lzss_pkg::S_STATUS;
            if (len_short_ff) begin
               stat_code_in = lzss_pkg::STAT_SHORT;
            end else if (decl_size_ff > lzss_pkg::MaxOutput) begin
               stat_code_in = lzss_pkg::STAT_CAP;
            end else if (over_bound) begin
               stat_code_in = lzss_pkg::STAT_BOUND;
            end else if (decl_size_ff == '0) begin
               stat_code_in = lzss_pkg::STAT_EMPTY;
            end else begin
               state_in = lzss_pkg::S_BODY;
            end
         end
         lzss_pkg::S_STATUS: begin
            if (out_ready) begin
               status_fire = 1'b1;
               state_in    = lzss_pkg::S_IDLE;
            end
         end
         lzss_pkg::S_LIT: begin
            if (out_ready) begin
               emit_fire = 1'b1;
               emit_data = lit_ff;
               state_in  = emit_eos ? lzss_pkg::S_IDLE : lzss_pkg::S_BODY;
            end
         end
         lzss_pkg::S_COPY_RD: begin
            rd_en       = 1'b1;
            rd_valid_in = win_valid_ff[rd_ptr_ff];
            fwd_in      = 1'b0;
            rd_ptr_in   = rd_ptr_ff + 8'd1;
            state_in    = lzss_pkg::S_COPY_EMIT;
         end
         lzss_pkg::S_COPY_EMIT: begin
            emit_data = fwd_ff ? fwd_data_ff : (rd_valid_ff ? ram_q : 8'd0);
            if (out_ready) begin
               emit_fire = 1'b1;
               remain_in = remain_ff - 3'd1;
               if (emit_eos) begin
                  state_in = lzss_pkg::S_IDLE;
               end else if (remain_ff == 3'd1) begin
                  state_in = lzss_pkg::S_BODY;
               end else begin
                  // next read; forward the byte written this cycle for distance one
                  rd_en       = 1'b1;
                  rd_valid_in = win_valid_ff[rd_ptr_ff];
                  fwd_in      = (rd_ptr_ff == wr_ptr_ff);
                  fwd_data_in = emit_data;
                  rd_ptr_in   = rd_ptr_ff + 8'd1;
               end
            end
         end
         default: begin
            state_in = lzss_pkg::S_IDLE;
         end
      endcase

      if (emit_fire) begin
         win_valid_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in               = wr_ptr_ff + 8'd1;
         prod_count_in           = prod_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_eos_in   = rsp_eos_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_data;
         rsp_eos_in   = emit_eos;
         rsp_stat_in  = lzss_pkg::STAT_DATA;
      end else if (status_fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = '0;
         rsp_eos_in   = 1'b1;
         rsp_stat_in  = stat_code_ff;
      end
   end

`ifndef SYNTHESIS
   a_copy_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzss_pkg::S_COPY_EMIT) |-> (remain_ff != 3'd0))
      else $error("copy emit state with no bytes left");

   a_status_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_stat_ff != lzss_pkg::STAT_DATA)) |->
      (rsp_eos_ff && (rsp_byte_ff == 8'd0)))
      else $error("status item without end of stream or with nonzero byte");

   a_eos_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_eos) |=> (state_ff == lzss_pkg::S_IDLE))
      else $error("engine kept running after the last data item");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (emit_fire || status_fire) |-> out_ready)
      else $error("result loaded into an occupied, stalled output register");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/lzss_decompressor_256_window_tb.sv -----
// Self-checking testbench for lzss_decompressor_256_window: directed table, then random
// streams checked item by item against a byte-level LZSS decoder kept in the bench.
// Depends on lzss_pkg and the RTL of lzss_decompressor_256_window.
`timescale 1ns / 100ps

module lzss_decompressor_256_window_tb;

   localparam int CycleLimit   = 400000;
   localparam int SettleCycles = 10;
   localparam int HoldCycles   = 300;
   localparam int DrainLimit   = 20000;
   localparam int ItemTarget   = 150;

   typedef enum logic [1:0] {DEC_IDLE, DEC_HEADER, DEC_BODY} dec_phase_type;
   typedef enum logic [1:0] {ROW_CSR, ROW_DATA, ROW_STATUS} row_kind_type;

   typedef struct packed {
      logic [7:0]           data;
      logic                 eos;
      lzss_pkg::status_type status;
   } lz_result_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [25:0]          value;
      logic                 start;
      lzss_pkg::status_type status;
   } stim_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte      = 8'h00;
   logic        req_stream_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_stream;
   logic [2:0]  rsp_status;
   logic        csr_wr_en        = 1'b0;
   logic [25:0] csr_wr_data      = 26'd0;

   lz_result_type decoded_q[$];
   stim_row_type  stim_rows[$];
   logic [7:0]    body_q[$];
   int            mismatches   = 0;
   int            live_items   = 0;
   int            gap_mode     = 0;
   bit            hold_off_req = 1'b0;

   // decoder state
   dec_phase_type dec_phase;
   logic [25:0]   in_len;
   logic [2:0]    hdr_cnt;
   logic [31:0]   hdr_size;
   logic [24:0]   produced;
   logic [10:0]   tok_bits;
   int            tok_cnt;
   logic [7:0]    window [256];
   logic [7:0]    wr_ptr;

   lzss_decompressor_256_window dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_stream_start  (req_stream_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint size_limit(input logic [25:0] len);
      return ((longint'(len) - 4) * 40) / 11 + 64;
   endfunction

   task automatic push_result(input logic [7:0] d, input logic e,
                              input lzss_pkg::status_type s);
      lz_result_type res;
      res.data   = d;
      res.eos    = e;
      res.status = s;
      decoded_q.insert(decoded_q.size(), res);
   endtask

   task automatic clear_stream();
      foreach (window[i]) window[i] = 8'h00;
      wr_ptr    = 8'h00;
      hdr_cnt   = '0;
      hdr_size  = '0;
      produced  = '0;
      tok_bits  = '0;
      tok_cnt   = 0;
      dec_phase = DEC_HEADER;
   endtask

   task automatic emit_decoded(input logic [7:0] v);
      logic last;
      window[wr_ptr] = v;
      wr_ptr++;
      produced++;
      last = ({7'd0, produced} == hdr_size);
      if (last) dec_phase = DEC_IDLE;
      push_result(v, last, lzss_pkg::STAT_DATA);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic s);
      logic [7:0] rd;
      int         len;
      int         i;
      int         j;
      if (s) begin
         clear_stream();
         if (in_len < 26'd4) begin
            dec_phase = DEC_IDLE;
            push_result(8'h00, 1'b1, lzss_pkg::STAT_SHORT);
            return;
         end
      end
      if (dec_phase == DEC_HEADER) begin
         hdr_size = {hdr_size[23:0], b};
         hdr_cnt++;
         if (hdr_cnt < 3'd4) return;
         hdr_cnt   = '0;
         dec_phase = DEC_IDLE;
         if (in_len < 26'd4) push_result(8'h00, 1'b1, lzss_pkg::STAT_SHORT);
         else if (hdr_size > lzss_pkg::MaxOutput) push_result(8'h00, 1'b1, lzss_pkg::STAT_CAP);
         else if (longint'(hdr_size) > size_limit(in_len))
            push_result(8'h00, 1'b1, lzss_pkg::STAT_BOUND);
         else if (hdr_size == 32'd0) push_result(8'h00, 1'b1, lzss_pkg::STAT_EMPTY);
         else dec_phase = DEC_BODY;
         return;
      end
      if (dec_phase != DEC_BODY) return;
      for (i = 7; i >= 0 && dec_phase == DEC_BODY; i--) begin
         tok_bits = {tok_bits[9:0], b[i]};
         tok_cnt++;
         if (!tok_bits[tok_cnt-1] && tok_cnt == 9) begin
            rd       = tok_bits[7:0];
            tok_bits = '0;
            tok_cnt  = 0;
            emit_decoded(rd);
         end else if (tok_bits[tok_cnt-1] && tok_cnt == 11) begin
            len      = tok_bits[9:8] + 2;
            rd       = wr_ptr - tok_bits[7:0] - 8'd1;
            tok_bits = '0;
            tok_cnt  = 0;
            for (j = 0; j < len && dec_phase == DEC_BODY; j++) begin
               emit_decoded(window[rd]);
               rd++;
            end
         end
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gap_mode == 0) return 0;
      if (gap_mode == 2 && r < 5) return $urandom_range(10, 30);
      if (r < 35) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic send_item(input logic [7:0] b, input logic s, input bit typed,
                            input lzss_pkg::status_type st);
      int gap;
      int n_before;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_stream_start <= s;
      do @(posedge clock); while (req_stall);
      if (s || dec_phase != DEC_IDLE) live_items++;
      n_before = decoded_q.size();
      decode_byte(b, s);
      if (typed) begin
         while (decoded_q.size() > n_before) void'(decoded_q.pop_back());
         push_result(8'h00, 1'b1, st);
      end
   endtask

   task automatic send_header(input logic [31:0] size);
      int i;
      for (i = 3; i >= 0; i--) send_item(size[i*8 +: 8], i == 3, 1'b0, lzss_pkg::STAT_DATA);
   endtask

   task automatic write_length(input logic [25:0] v);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      in_len = v;
   endtask

   // random token stream of at least n output bytes, packed MSB first
   task automatic build_body(input int n);
      bit         bits_q[$];
      int         made;
      int         i;
      logic [7:0] v;
      logic [1:0] lc;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) < 6) begin
            v = 8'($urandom);
            bits_q.insert(bits_q.size(), 1'b0);
            for (i = 7; i >= 0; i--) bits_q.insert(bits_q.size(), v[i]);
            made++;
         end else begin
            lc = 2'($urandom);
            v  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            bits_q.insert(bits_q.size(), 1'b1);
            bits_q.insert(bits_q.size(), lc[1]);
            bits_q.insert(bits_q.size(), lc[0]);
            for (i = 7; i >= 0; i--) bits_q.insert(bits_q.size(), v[i]);
            made += lc + 2;
         end
      end
      while (bits_q.size() % 8 != 0) bits_q.insert(bits_q.size(), 1'($urandom_range(0, 1)));
      body_q.delete();
      for (i = 0; i < bits_q.size(); i += 8) begin
         v = {bits_q[i], bits_q[i+1], bits_q[i+2], bits_q[i+3],
              bits_q[i+4], bits_q[i+5], bits_q[i+6], bits_q[i+7]};
         body_q.insert(body_q.size(), v);
      end
   endtask

   task automatic add_row(input row_kind_type k, input logic [25:0] v, input logic s,
                          input lzss_pkg::status_type st);
      stim_row_type row;
      row.kind   = k;
      row.value  = v;
      row.start  = s;
      row.status = st;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   always @(posedge clock) begin
      lz_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            $display("%0t: expected no item, got out_byte %02h eos %0d status %0d",
                     $time, rsp_out_byte, rsp_end_of_stream, rsp_status);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.data) begin
               mismatches++;
               $display("%0t: out_byte expected %02h, got %02h",
                        $time, want.data, rsp_out_byte);
            end
            if (rsp_end_of_stream !== want.eos) begin
               mismatches++;
               $display("%0t: end_of_stream expected %0d, got %0d",
                        $time, want.eos, rsp_end_of_stream);
            end
            if (rsp_status !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_status);
            end
         end
      end
   end

   initial begin
      int stall_mode;
      int stall_age;
      int stall_left;
      int r;
      stall_mode = 0;
      stall_age  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_req = 1'b0;
         end else begin
            if (stall_age == 0) begin
               stall_mode = $urandom_range(0, 2);
               stall_age  = $urandom_range(20, 100);
            end
            stall_age--;
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else if (stall_mode == 0) begin
               rsp_stall <= 1'b0;
            end else if (stall_mode == 2 && r < 4) begin
               stall_left = $urandom_range(8, 30);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= (r < 30);
            end
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [25:0] len_cfg;
      logic [31:0] size;
      int          holds_done;
      int          n_streams;
      int          pick;
      int          n;
      int          cut;
      int          r;
      int          k;
      int          i;
      int          drain_wait;
      bit          hold;

      clear_stream();
      dec_phase = DEC_IDLE;
      in_len    = '0;

      add_row(ROW_STATUS, 26'h0AB, 1'b1, lzss_pkg::STAT_SHORT);
      add_row(ROW_CSR,    26'd3,   1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_STATUS, 26'h000, 1'b1, lzss_pkg::STAT_SHORT);
      add_row(ROW_CSR,    26'd4,   1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b1, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_STATUS, 26'h041, 1'b0, lzss_pkg::STAT_BOUND);
      add_row(ROW_DATA,   26'h000, 1'b1, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_STATUS, 26'h000, 1'b0, lzss_pkg::STAT_EMPTY);
      add_row(ROW_DATA,   26'h000, 1'b1, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h006, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h07F, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h0F0, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_CSR,    26'h3FFFFFF, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h001, 1'b1, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h000, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h0FF, 1'b1, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h0FF, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_DATA,   26'h0FF, 1'b0, lzss_pkg::STAT_DATA);
      add_row(ROW_STATUS, 26'h0FF, 1'b0, lzss_pkg::STAT_CAP);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[row_i]) begin
         case (stim_rows[row_i].kind)
            ROW_CSR: begin
               write_length(stim_rows[row_i].value);
            end
            ROW_DATA: begin
               send_item(stim_rows[row_i].value[7:0], stim_rows[row_i].start, 1'b0,
                         lzss_pkg::STAT_DATA);
            end
            default: begin
               send_item(stim_rows[row_i].value[7:0], stim_rows[row_i].start, 1'b1,
                         stim_rows[row_i].status);
            end
         endcase
      end

      holds_done = 0;
      while (live_items < ItemTarget) begin
         r = $urandom_range(0, 9);
         if (r == 0) len_cfg = 26'($urandom_range(0, 3));
         else if (r == 1) len_cfg = 26'h3FFFFFF;
         else if (r < 6) len_cfg = 26'($urandom_range(4, 24));
         else len_cfg = 26'($urandom_range(25, 5000));
         write_length(len_cfg);
         n_streams = $urandom_range(3, 6);
         for (k = 0; k < n_streams && live_items < ItemTarget; k++) begin
            gap_mode = $urandom_range(0, 2);
            pick     = $urandom_range(0, 99);
            hold     = 1'b0;
            if (in_len >= 26'd4 && ((holds_done == 0 && live_items >= 40) ||
                                    (holds_done == 1 && live_items >= 110))) begin
               hold         = 1'b1;
               hold_off_req = 1'b1;
               holds_done++;
               pick     = 0;
               gap_mode = 0;
            end
            if (pick < 70) begin
               if (hold) n = 48;
               else if ($urandom_range(0, 4) == 0) n = $urandom_range(21, 64);
               else n = $urandom_range(1, 20);
               build_body(n);
               cut = body_q.size();
               r   = hold ? 9 : $urandom_range(0, 9);
               if (r < 3) cut = $urandom_range(0, body_q.size() - 1);
               send_header(32'(n));
               for (i = 0; i < cut; i++) send_item(body_q[i], 1'b0, 1'b0, lzss_pkg::STAT_DATA);
               // pad with zeros as the source does past its data; r == 0 drops the rest
               if (r != 0) begin
                  while (dec_phase == DEC_BODY)
                     send_item(8'h00, 1'b0, 1'b0, lzss_pkg::STAT_DATA);
               end
            end else if (pick < 80) begin
               size = 32'(size_limit(in_len) + 1 + $urandom_range(0, 300));
               send_header(size);
            end else if (pick < 86) begin
               size = {8'($urandom_range(2, 255)), 24'($urandom)};
               send_header(size);
            end else if (pick < 89) begin
               send_header(lzss_pkg::MaxOutput + 32'd1);
            end else if (pick < 93) begin
               send_header(32'd0);
            end else begin
               if (dec_phase == DEC_IDLE) begin
                  repeat ($urandom_range(1, 4))
                     send_item(8'($urandom), 1'b0, 1'b0, lzss_pkg::STAT_DATA);
               end
               send_item(8'h00, 1'b1, 1'b0, lzss_pkg::STAT_DATA);
               send_item(8'($urandom), 1'b0, 1'b0, lzss_pkg::STAT_DATA);
            end
         end
         // close any open stream so the next length write finds the block idle
         if (dec_phase != DEC_IDLE) send_header(32'd0);
      end

      req_valid <= 1'b0;
      drain_wait = 0;
      while (decoded_q.size() != 0 && drain_wait < DrainLimit) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (decoded_q.size() != 0) begin
         mismatches += decoded_q.size();
         $display("%0t: %0d expected items never arrived", $time, decoded_q.size());
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lzss_pkg.sv
rtl/lzss_ram.sv
rtl/lzss_unpack.sv
rtl/lzss_decompressor_256_window.sv
tb/sv/lzss_decompressor_256_window_tb.sv
